[sv/dba_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the disk block allocator.
// No dependencies; imported by disk_block_allocator_core.
package dba_pkg;

	typedef enum logic [1:0] {
		METH_CONTIG  = 2'd0,
		METH_LINKED  = 2'd1,
		METH_INDEXED = 2'd2,
		METH_UNDEF   = 2'd3
	} method_t;

	typedef enum logic [1:0] {
		ST_GRANT   = 2'd0,
		ST_INVALID = 2'd1,
		ST_NOSPACE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_GRANT,
		S_REPORT
	} state_t;

	localparam int unsigned METHOD_W = 2;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned NEED_W   = 8;
	localparam int unsigned BLKIDX_W = 6;

endpackage

[sv/disk_block_allocator_core.sv]
`timescale 1ns / 1ps
// Channel   Dir  tdata                   tuser                            tlast
// s_axis    in   block_count [6:0]       method [1:0]                     -
// m_axis    out  block_index [5:0]       status [1:0], is_index_block [2] last
//
// A request is accepted in S_IDLE; S_SCAN then checks the used map bit by bit as
// it rotates through a shift register, S_DECIDE decides, and S_GRANT rotates the
// map again while granting blocks.
// Failed requests emit one status from S_REPORT, entered from S_IDLE or S_DECIDE.
// Reset marks every block free. A stalled output holds the grant pass in place.
// Bitmap allocator top level; depends on dba_pkg.
module disk_block_allocator_core
	import dba_pkg::*;
#(
	parameter int unsigned NUM_BLOCKS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // block_count [6:0], zero [7]
	input  logic [1:0] s_axis_tuser,   // method [1:0]
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // block_index [5:0], zero [7:6]
	output logic [2:0] m_axis_tuser,   // status [1:0], is_index_block [2]
	output logic       m_axis_tlast
);

	localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
	localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);

	state_t                  state_q, state_d;
	logic [NUM_BLOCKS-1:0]   map_q;
	logic [IDX_W-1:0]        pos_q;
	logic [CNT_W-1:0]        need_q;
	logic [CNT_W-1:0]        run_q;
	logic [CNT_W-1:0]        free_q;
	logic [CNT_W-1:0]        k_q;
	logic [IDX_W-1:0]        start_q;
	logic                    found_q;
	method_t                 method_q;
	status_t                 status_q;

	logic                    out_valid_q;
	logic [BLKIDX_W-1:0]     out_idx_q;
	status_t                 out_status_q;
	logic                    out_isidx_q;
	logic                    out_last_q;

	logic                    accept;
	logic                    out_free;
	logic [NEED_W-1:0]       need_in;
	logic                    bad_in;
	logic                    big_in;
	logic                    head;
	logic                    at_end;
	logic                    grant_now;
	logic                    rotate;
	logic                    emit_grant;
	logic                    emit_status;
	logic                    alloc_ok;
	logic [CNT_W-1:0]        run_next;
	logic [IDX_W:0]          start_calc;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign need_in   = {1'b0, s_axis_tdata[COUNT_W-1:0]}
		+ NEED_W'(s_axis_tuser == METH_INDEXED);
	assign bad_in    = (s_axis_tdata[COUNT_W-1:0] == '0) || (s_axis_tuser == METH_UNDEF);
	assign big_in    = need_in > NEED_W'(NUM_BLOCKS);
	assign head      = map_q[0];
	assign at_end    = pos_q == IDX_W'(NUM_BLOCKS - 1);
	assign run_next  = head ? '0 : run_q + 1'b1;
	assign start_calc = {1'b0, pos_q} + 1'b1 - (IDX_W + 1)'(need_q);
	assign alloc_ok  = (method_q == METH_CONTIG) ? found_q : (free_q >= need_q);
	assign grant_now = (state_q == S_GRANT) && !head && (pos_q >= start_q)
		&& (k_q < need_q);

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		rotate        = 1'b0;
		emit_grant    = 1'b0;
		emit_status   = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = (bad_in || big_in) ? S_REPORT : S_SCAN;
				end
			end
			S_SCAN: begin
				rotate = 1'b1;
				if (at_end) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = alloc_ok ? S_GRANT : S_REPORT;
			end
			S_GRANT: begin
				if (!grant_now || out_free) begin
					rotate     = 1'b1;
					emit_grant = grant_now;
					if (at_end) begin
						state_d = S_IDLE;
					end
				end
			end
			S_REPORT: begin
				if (out_free) begin
					emit_status = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q       <= '0;
			pos_q       <= '0;
			run_q       <= '0;
			free_q      <= '0;
			k_q         <= '0;
			start_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pos_q   <= '0;
				run_q   <= '0;
				free_q  <= '0;
				k_q     <= '0;
				start_q <= '0;
				found_q <= 1'b0;
			end
			if (rotate) begin
				map_q <= {head || grant_now, map_q[NUM_BLOCKS-1:1]};
				pos_q <= at_end ? '0 : pos_q + 1'b1;
			end
			if (state_q == S_SCAN) begin
				run_q  <= run_next;
				free_q <= free_q + CNT_W'(!head);
				if (!found_q && !head && run_next == need_q) begin
					found_q <= 1'b1;
					start_q <= start_calc[IDX_W-1:0];
				end
			end
			if (state_q == S_DECIDE && method_q != METH_CONTIG) begin
				start_q <= '0;
			end
			if (emit_grant) begin
				k_q <= k_q + 1'b1;
			end
			if (emit_grant || emit_status) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			method_q <= method_t'(s_axis_tuser);
			need_q   <= big_in ? '0 : need_in[CNT_W-1:0];
			status_q <= bad_in ? ST_INVALID : ST_NOSPACE;
		end
		if (state_q == S_DECIDE) begin
			status_q <= ST_NOSPACE;
		end
		if (emit_grant) begin
			out_idx_q    <= BLKIDX_W'(pos_q);
			out_status_q <= ST_GRANT;
			out_isidx_q  <= (method_q == METH_INDEXED) && (k_q == '0);
			out_last_q   <= k_q == need_q - 1'b1;
		end else if (emit_status) begin
			out_idx_q    <= '0;
			out_status_q <= status_q;
			out_isidx_q  <= 1'b0;
			out_last_q   <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_idx_q};
	assign m_axis_tuser  = {out_isidx_q, out_status_q};
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("request accepted but controller stayed idle");

	a_grant_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GRANT |-> k_q <= need_q)
		else $error("more blocks granted than requested");

	a_failure_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1:0] != ST_GRANT)
			|-> (m_axis_tlast && m_axis_tdata == 8'd0 && !m_axis_tuser[2]))
		else $error("failure result carries block data");

	a_grant_pass_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GRANT && rotate && at_end) |-> (k_q + CNT_W'(emit_grant)) == need_q)
		else $error("grant pass ended short of the requested blocks");
`endif

endmodule
